// ----- rtl/bpr_pkg.sv -----
// bus packet receiver package: word codes, preamble positions and shared types
// no dependencies
`default_nettype none

package bpr_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_HDR_ERR = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_ADDR   = 2'd0;
  localparam logic [1:0] REG_BCAST_ADDR = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  // preamble layout, byte positions within the packet
  localparam int PosW = 9;
  localparam logic [PosW-1:0] POS_START     = 9'd0;
  localparam logic [PosW-1:0] POS_SYNC_MARK = 9'd5;   // first five bytes are zero sync
  localparam logic [PosW-1:0] POS_ADDR      = 9'd6;
  localparam logic [PosW-1:0] POS_SUB       = 9'd7;
  localparam logic [PosW-1:0] POS_CODE      = 9'd8;
  localparam logic [PosW-1:0] POS_LEN       = 9'd9;
  localparam logic [PosW-1:0] PREAMBLE_BYTES = 9'd10;

  localparam logic [7:0] SYNC_ZERO = 8'h00;
  localparam logic [7:0] SYNC_MARK = 8'hFF;

  // reset values of the configuration registers
  localparam logic [7:0]  OWN_ADDR_RST  = 8'd0;
  localparam logic [7:0]  BCAST_ADDR_RST = 8'd255;
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [7:0]  broadcast_address;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       last;
    logic [7:0] packet_code;
    logic [7:0] sub_address;
    logic       is_broadcast;
    logic       not_for_us;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/bpr_if.sv -----
// channel interfaces of the bus packet receiver: input words, result words, config writes
// no dependencies
`default_nettype none

interface bpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface bpr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic       last;
  logic [7:0] packet_code;
  logic [7:0] sub_address;
  logic       is_broadcast;
  logic       not_for_us;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output last, output packet_code, output sub_address,
                  output is_broadcast, output not_for_us, input ready);
  modport sink (input valid, input kind, input data_byte, input data_index,
                input last, input packet_code, input sub_address,
                input is_broadcast, input not_for_us, output ready);
endinterface

interface bpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bus_packet_receiver.sv -----
// Bus packet receiver. Takes one word per clock (a received byte or a time tick) and
// gives at most one result word for it. A word passes an input register, the decode
// logic and a result register, which offers its result on the output channel;
// throughput is one word per cycle while the result side keeps taking words. A stall on
// the result side holds the word in the input register, after which rx.ready drops.
// Config writes are always taken and belong only to times when no packet work is pending.
// depends on bpr_pkg, bpr_if, bpr_core and bpr_out_reg
`default_nettype none

module bus_packet_receiver (
  input  wire logic  clk,
  input  wire logic  rst,
  bpr_in_if.sink     rx,
  bpr_out_if.source  res,
  bpr_cfg_if.sink    cfg
);
  import bpr_pkg::*;

  logic  in_valid;
  item_t in_item;
  cfg_t  cfg_regs;
  res_t  core_res;
  logic  core_has_res;
  logic  out_free;
  logic  step;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.own_address       <= OWN_ADDR_RST;
      cfg_regs.broadcast_address <= BCAST_ADDR_RST;
      cfg_regs.timeout_ticks     <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OWN_ADDR:   cfg_regs.own_address       <= cfg.data[7:0];
        REG_BCAST_ADDR: cfg_regs.broadcast_address <= cfg.data[7:0];
        REG_TIMEOUT:    cfg_regs.timeout_ticks     <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // word moves on when it makes no result or the result register has room
  assign step     = in_valid && (!core_has_res || out_free);
  assign rx.ready = !in_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_item.action  <= rx.action;
      in_item.rx_byte <= rx.rx_byte;
    end
  end

  bpr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (in_item),
    .cfg     (cfg_regs),
    .step    (step),
    .res     (core_res),
    .has_res (core_has_res)
  );

  bpr_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && core_has_res),
    .res     (core_res),
    .free    (out_free),
    .res_out (res)
  );

endmodule

`default_nettype wire

// ----- rtl/bpr_core.sv -----
// packet decode: byte position tracking, header check, timeout and result building
// depends on bpr_pkg
`default_nettype none

module bpr_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bpr_pkg::item_t item,
  input  wire bpr_pkg::cfg_t  cfg,
  input  wire logic          step,
  output bpr_pkg::res_t      res,
  output logic               has_res
);
  import bpr_pkg::*;

  logic [PosW-1:0] pos, pos_next;
  logic            header_good, header_good_next;
  logic [7:0]      target_address, target_address_next;
  logic [7:0]      sub_addr_reg, sub_addr_reg_next;
  logic [7:0]      code_reg, code_reg_next;
  logic [7:0]      data_length, data_length_next;
  logic [15:0]     idle_ticks, idle_ticks_next;

  logic            bc;
  logic            nfu;
  logic [PosW-1:0] pos_plus_one;
  logic [PosW-1:0] data_idx;
  logic            fin;
  logic            hg;
  res_t            info_res;
  res_t            bare_res;

  // address match flags
  assign bc  = (target_address == cfg.broadcast_address);
  assign nfu = !bc && (target_address != cfg.own_address);

  assign pos_plus_one = pos + 9'd1;
  assign data_idx     = pos - PREAMBLE_BYTES;
  // idx + 1 >= length, with idx + 1 = pos - 9
  assign fin          = ((pos - POS_LEN) >= {1'b0, data_length});

  // result templates: with packet info, and bare (error or timeout)
  always_comb begin
    info_res              = '0;
    info_res.packet_code  = code_reg;
    info_res.sub_address  = sub_addr_reg;
    info_res.is_broadcast = bc;
    info_res.not_for_us   = nfu;
    bare_res              = '0;
    bare_res.last         = 1'b1;
  end

  // next state and result
  always_comb begin
    pos_next            = pos;
    header_good_next    = header_good;
    target_address_next = target_address;
    sub_addr_reg_next   = sub_addr_reg;
    code_reg_next       = code_reg;
    data_length_next    = data_length;
    idle_ticks_next     = idle_ticks;
    hg                  = header_good;
    res                 = '0;
    has_res             = 1'b0;

    if (item.action == ACT_TICK) begin
      if (pos != POS_START) begin
        if (idle_ticks >= cfg.timeout_ticks) begin
          res           = bare_res;
          res.kind      = KIND_TIMEOUT;
          has_res       = 1'b1;
          pos_next        = POS_START;
          idle_ticks_next = '0;
        end else begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks_next = '0;
      if (pos < PREAMBLE_BYTES) begin
        pos_next = pos_plus_one;
        if (pos == POS_START) begin
          hg = 1'b1;
        end
        if (pos < POS_SYNC_MARK) begin
          if (item.rx_byte != SYNC_ZERO) begin
            hg = 1'b0;
          end
        end else if (pos == POS_SYNC_MARK) begin
          if (item.rx_byte != SYNC_MARK) begin
            hg = 1'b0;
          end
        end else if (pos == POS_ADDR) begin
          target_address_next = item.rx_byte;
        end else if (pos == POS_SUB) begin
          sub_addr_reg_next = item.rx_byte;
        end else if (pos == POS_CODE) begin
          code_reg_next = item.rx_byte;
        end else begin
          data_length_next = item.rx_byte;
          // empty packet ends on the length byte
          if (item.rx_byte == 8'd0) begin
            has_res  = 1'b1;
            pos_next = POS_START;
            if (hg) begin
              res      = info_res;
              res.kind = KIND_EMPTY;
              res.last = 1'b1;
            end else begin
              res      = bare_res;
              res.kind = KIND_HDR_ERR;
            end
          end
        end
        header_good_next = hg;
      end else begin
        // data phase
        if (fin) begin
          has_res  = 1'b1;
          pos_next = POS_START;
          if (header_good) begin
            res            = info_res;
            res.kind       = KIND_DATA;
            res.data_byte  = item.rx_byte;
            res.data_index = data_idx[7:0];
            res.last       = 1'b1;
          end else begin
            res      = bare_res;
            res.kind = KIND_HDR_ERR;
          end
        end else begin
          pos_next = pos_plus_one;
          if (header_good) begin
            has_res        = 1'b1;
            res            = info_res;
            res.kind       = KIND_DATA;
            res.data_byte  = item.rx_byte;
            res.data_index = data_idx[7:0];
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= POS_START;
      header_good    <= 1'b1;
      target_address <= '0;
      sub_addr_reg   <= '0;
      code_reg       <= '0;
      data_length    <= '0;
      idle_ticks     <= '0;
    end else if (step) begin
      pos            <= pos_next;
      header_good    <= header_good_next;
      target_address <= target_address_next;
      sub_addr_reg   <= sub_addr_reg_next;
      code_reg       <= code_reg_next;
      data_length    <= data_length_next;
      idle_ticks     <= idle_ticks_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bpr_out_reg.sv -----
// result register driving the output channel
// depends on bpr_pkg and bpr_if
`default_nettype none

module bpr_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire bpr_pkg::res_t res,
  output logic               free,
  bpr_out_if.source          res_out
);
  import bpr_pkg::*;

  logic valid;
  res_t data;

  // slot can take a word when empty or emptied this cycle
  assign free = !valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign res_out.valid        = valid;
  assign res_out.kind         = data.kind;
  assign res_out.data_byte    = data.data_byte;
  assign res_out.data_index   = data.data_index;
  assign res_out.last         = data.last;
  assign res_out.packet_code  = data.packet_code;
  assign res_out.sub_address  = data.sub_address;
  assign res_out.is_broadcast = data.is_broadcast;
  assign res_out.not_for_us   = data.not_for_us;

endmodule

`default_nettype wire
